/* rtl/bmr_pkg.sv */
// shared types, constants and helpers of the binary morphology row engine
`timescale 1ns / 1ps
`default_nettype none

package bmr_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int MAX_SE      = 7;
    localparam int COL_OFS     = MAX_SE / 2;
    localparam int SE_SPAN     = MAX_SE - 1;
    localparam int LINE_W      = MAX_WIDTH + 2 * COL_OFS;
    localparam int EXT_W       = LINE_W + SE_SPAN;
    localparam int MASK_W      = MAX_SE * MAX_SE;
    localparam int CFG_INDEX_W = 3;
    localparam logic [3:0] FILL_TOP = 4'd15;

    typedef enum logic [1:0] {
        OP_DILATE = 2'd0,
        OP_ERODE  = 2'd1,
        OP_OPEN   = 2'd2,
        OP_CLOSE  = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OP_MODE    = 3'd0,
        REG_IMG_WIDTH  = 3'd1,
        REG_SE_ROWS    = 3'd2,
        REG_SE_COLS    = 3'd3,
        REG_ORIGIN_ROW = 3'd4,
        REG_ORIGIN_COL = 3'd5,
        REG_SE_MASK    = 3'd6
    } reg_idx_t;

    // one row in the padded column domain, column x at bit x+COL_OFS
    typedef logic [LINE_W-1:0] line_t;
    typedef line_t [MAX_SE-1:0] win_t;
    typedef logic [EXT_W-1:0] ext_t;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] row_bits;
        logic                 last_row;
    } row_item_t;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] result_row;
        logic                 last;
    } result_item_t;

    // settled configuration: sizes clamped, origin inside the element
    typedef struct packed {
        op_t               op;
        logic [5:0]        kw;
        logic [2:0]        kr;
        logic [2:0]        kc;
        logic [2:0]        korow;
        logic [2:0]        kocol;
        logic [MASK_W-1:0] se_mask;
    } cfg_t;

    function automatic logic [3:0] fill_inc(input logic [3:0] f);
        return (f == FILL_TOP) ? FILL_TOP : f + 4'd1;
    endfunction

endpackage

`default_nettype wire

/* rtl/bmr_morph.sv */
// one dilation or erosion pass over a window of padded rows
`timescale 1ns / 1ps
`default_nettype none

module bmr_morph (
    input  bmr_pkg::cfg_t  cfg,
    input  logic           dilate,
    input  bmr_pkg::win_t  win,
    output bmr_pkg::line_t morph_line
);

    logic [2:0]                  ctr;
    logic [2:0]                  idx;
    logic [bmr_pkg::MAX_SE-1:0]  se_row;
    logic [bmr_pkg::MAX_SE-1:0]  cells;
    bmr_pkg::ext_t               ext;
    bmr_pkg::ext_t               upad;
    bmr_pkg::ext_t               t;
    bmr_pkg::ext_t               v;
    bmr_pkg::line_t              rowv;
    bmr_pkg::line_t              acc;

    always_comb
    begin
        ctr    = cfg.kr - 3'd1 - cfg.korow;
        // erosion also needs the pixel itself
        acc    = dilate ? '0 : win[ctr];
        idx    = '0;
        se_row = '0;
        cells  = '0;
        ext    = '0;
        upad   = '0;
        t      = '0;
        v      = '0;
        rowv   = '0;
        for (int r = 0; r < bmr_pkg::MAX_SE; r++)
        begin
            // window slot r pairs with element row r (dilation) or kr-1-r (erosion)
            idx = dilate ? 3'(r) : (cfg.kr - 3'd1 - 3'(r));
            se_row = '0;
            for (int i = 0; i < bmr_pkg::MAX_SE; i++)
            begin
                if (3'(i) == idx)
                begin
                    se_row = cfg.se_mask[i*bmr_pkg::MAX_SE +: bmr_pkg::MAX_SE];
                end
            end
            for (int j = 0; j < bmr_pkg::MAX_SE; j++)
            begin
                cells[j] = (3'(r) < cfg.kr) && (3'(j) < cfg.kc) && se_row[j];
            end
            ext  = bmr_pkg::EXT_W'(win[r]);
            upad = {win[r], {bmr_pkg::SE_SPAN{1'b0}}};
            t    = '0;
            v    = '1;
            for (int j = 0; j < bmr_pkg::MAX_SE; j++)
            begin
                if (cells[j])
                begin
                    t = t | (ext << j);
                    v = v & (upad >> j);
                end
            end
            if (dilate)
            begin
                rowv = bmr_pkg::LINE_W'(t >> cfg.kocol);
                acc  = acc | rowv;
            end
            else
            begin
                rowv = bmr_pkg::LINE_W'(v >> (3'(bmr_pkg::SE_SPAN) - cfg.kocol));
                acc  = acc & rowv;
            end
        end
        morph_line = acc;
    end

endmodule

`default_nettype wire

/* rtl/binary_morphology_row_engine_unit.sv */
// top level of the binary morphology row engine
`timescale 1ns / 1ps
`default_nettype none

// Binary dilation, erosion, opening or closing of an image up to 32 pixels
// wide that arrives one row per item, top row first, with last_row on the
// final row. Rows are taken at one per cycle unless draining or held by a
// stalled output: each row is one window update (and for opening/closing
// the first pass into the intermediate window) in its tick cycle, then the final
// pass reads the windows into the result register once the output is free.
// Result rows lag the input by the element's look-ahead (origin_row for
// dilation, se_rows-1-origin_row for erosion, se_rows-1 for the cascades);
// after the last row the engine drains that many further rows (at most 6)
// with zero fill, during which one further row may wait in the input
// register. The windows then start fresh for the next image.
// There is no start-up clearing pass.
module binary_morphology_row_engine_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                row_valid,
    output logic                                row_stall,
    input  bmr_pkg::row_item_t                  row_item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output bmr_pkg::result_item_t               result_item,
    input  logic                                cfg_we,
    input  logic [bmr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bmr_pkg::MASK_W-1:0]          cfg_data
);

    // configuration registers
    bmr_pkg::op_t                op_mode_reg;
    logic [5:0]                  img_width_reg;
    logic [2:0]                  se_rows_reg;
    logic [2:0]                  se_cols_reg;
    logic [2:0]                  origin_row_reg;
    logic [2:0]                  origin_col_reg;
    logic [bmr_pkg::MASK_W-1:0]  se_mask_reg;
    bmr_pkg::cfg_t               cfg;

    // input register
    logic                          in_full_reg;
    logic                          in_full_next;
    logic [bmr_pkg::MAX_WIDTH-1:0] in_row_reg;
    logic                          in_last_reg;
    logic                          row_accept;

    // window state
    logic [bmr_pkg::MAX_SE-1:0][bmr_pkg::MAX_WIDTH-1:0] input_window_reg;
    logic [bmr_pkg::MAX_SE-1:0][bmr_pkg::MAX_WIDTH-1:0] input_window_next;
    logic [bmr_pkg::MAX_SE-1:0][bmr_pkg::MAX_WIDTH-1:0] in_eff;
    bmr_pkg::win_t   middle_window_reg;
    bmr_pkg::win_t   middle_window_next;
    bmr_pkg::win_t   mid_eff;
    bmr_pkg::win_t   inw_a;
    bmr_pkg::win_t   inw_b;
    bmr_pkg::win_t   win_b;
    logic [3:0]      input_fill_reg;
    logic [3:0]      input_fill_next;
    logic [3:0]      middle_fill_reg;
    logic [3:0]      middle_fill_next;
    logic [3:0]      in_fill_eff;
    logic [3:0]      mid_fill_eff;
    logic            clear_pending_reg;
    logic [2:0]      drain_reg;
    logic [2:0]      drain_next;

    // tick
    logic                          draining;
    logic                          tick_src;
    logic                          tick_fire;
    logic                          tick_final;
    logic                          in_take;
    logic                          cascade;
    logic                          emit;
    logic                          mid_kill;
    logic [2:0]                    lag;
    logic [1:0]                    rf;
    logic [1:0]                    cf;
    logic [bmr_pkg::MAX_WIDTH-1:0] width_mask;
    logic [bmr_pkg::MAX_WIDTH-1:0] tick_row;
    bmr_pkg::line_t                img_mask;
    bmr_pkg::line_t                close_span;
    bmr_pkg::line_t                mid_raw;
    bmr_pkg::line_t                mid_line;
    bmr_pkg::line_t                res_raw;
    logic                          dilate_a;
    logic                          dilate_b;

    // final pass and output register
    logic                   b_valid_reg;
    logic                   b_valid_next;
    logic                   b_last_reg;
    logic                   b_hold;
    logic                   b_load;
    logic                   out_free;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    bmr_pkg::result_item_t  out_item_reg;

    // ---------------------------------------------------------------
    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg    <= bmr_pkg::OP_DILATE;
            img_width_reg  <= 6'd32;
            se_rows_reg    <= 3'd3;
            se_cols_reg    <= 3'd3;
            origin_row_reg <= 3'd1;
            origin_col_reg <= 3'd1;
            se_mask_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bmr_pkg::REG_OP_MODE:    op_mode_reg    <= bmr_pkg::op_t'(cfg_data[1:0]);
                bmr_pkg::REG_IMG_WIDTH:  img_width_reg  <= cfg_data[5:0];
                bmr_pkg::REG_SE_ROWS:    se_rows_reg    <= cfg_data[2:0];
                bmr_pkg::REG_SE_COLS:    se_cols_reg    <= cfg_data[2:0];
                bmr_pkg::REG_ORIGIN_ROW: origin_row_reg <= cfg_data[2:0];
                bmr_pkg::REG_ORIGIN_COL: origin_col_reg <= cfg_data[2:0];
                bmr_pkg::REG_SE_MASK:    se_mask_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.op      = op_mode_reg;
        cfg.kr      = (se_rows_reg == 3'd0) ? 3'd1 : se_rows_reg;
        cfg.kc      = (se_cols_reg == 3'd0) ? 3'd1 : se_cols_reg;
        cfg.korow   = (origin_row_reg < cfg.kr) ? origin_row_reg : cfg.kr - 3'd1;
        cfg.kocol   = (origin_col_reg < cfg.kc) ? origin_col_reg : cfg.kc - 3'd1;
        cfg.kw      = (img_width_reg > 6'(bmr_pkg::MAX_WIDTH)) ?
                      6'(bmr_pkg::MAX_WIDTH) : img_width_reg;
        cfg.se_mask = se_mask_reg;
    end

    // ---------------------------------------------------------------
    // masks and look-ahead
    assign cascade = (cfg.op == bmr_pkg::OP_OPEN) || (cfg.op == bmr_pkg::OP_CLOSE);
    assign rf      = 2'(cfg.kr >> 1);
    assign cf      = 2'(cfg.kc >> 1);

    always_comb
    begin
        unique case (cfg.op)
            bmr_pkg::OP_DILATE: lag = cfg.korow;
            bmr_pkg::OP_ERODE:  lag = cfg.kr - 3'd1 - cfg.korow;
            default:            lag = cfg.kr - 3'd1;
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < bmr_pkg::MAX_WIDTH; j++)
        begin
            width_mask[j] = (6'(j) < cfg.kw);
        end
        for (int b = 0; b < bmr_pkg::LINE_W; b++)
        begin
            img_mask[b]   = (7'(b) >= 7'(bmr_pkg::COL_OFS)) &&
                            (7'(b) < 7'(cfg.kw) + 7'(bmr_pkg::COL_OFS));
            // closing keeps the dilated row on a border of half the element
            close_span[b] = (7'(b) + 7'(cf) >= 7'(bmr_pkg::COL_OFS)) &&
                            (7'(b) <= 7'(cfg.kw) + 7'(bmr_pkg::COL_OFS) - 7'd1 + 7'(cf));
        end
    end

    // ---------------------------------------------------------------
    // handshake and tick control
    assign draining   = (drain_reg != 3'd0);
    assign out_free   = !out_valid_reg || !result_stall;
    assign b_hold     = b_valid_reg && !out_free;
    assign b_load     = b_valid_reg && out_free;
    assign tick_src   = draining || in_full_reg;
    assign tick_fire  = tick_src && !b_hold;
    assign in_take    = tick_fire && !draining;
    assign row_stall  = in_full_reg && !in_take;
    assign row_accept = row_valid && !row_stall;
    assign tick_final = draining ? (drain_reg == lag) : (in_last_reg && (lag == 3'd0));
    assign tick_row   = draining ? '0 : (in_row_reg & width_mask);

    // a finished image clears its windows on the first tick of the next one
    assign in_eff       = clear_pending_reg ? '0 : input_window_reg;
    assign mid_eff      = clear_pending_reg ? '0 : middle_window_reg;
    assign in_fill_eff  = clear_pending_reg ? 4'd0 : input_fill_reg;
    assign mid_fill_eff = clear_pending_reg ? 4'd0 : middle_fill_reg;

    assign input_window_next = {in_eff[bmr_pkg::MAX_SE-2:0], tick_row};

    always_comb
    begin
        for (int k = 0; k < bmr_pkg::MAX_SE; k++)
        begin
            inw_a[k] = {{bmr_pkg::COL_OFS{1'b0}}, input_window_next[k],
                        {bmr_pkg::COL_OFS{1'b0}}};
            inw_b[k] = {{bmr_pkg::COL_OFS{1'b0}}, input_window_reg[k],
                        {bmr_pkg::COL_OFS{1'b0}}};
        end
    end

    assign dilate_a = (cfg.op == bmr_pkg::OP_CLOSE);
    assign dilate_b = (cfg.op == bmr_pkg::OP_DILATE) || (cfg.op == bmr_pkg::OP_OPEN);

    bmr_morph u_first_pass (
        .cfg        (cfg),
        .dilate     (dilate_a),
        .win        (inw_a),
        .morph_line (mid_raw)
    );

    // intermediate rows above the image border or past the drained border are empty
    assign mid_kill = (5'(in_fill_eff) + 5'(rf) < 5'(cfg.korow)) ||
                      (4'(drain_reg) > 4'(cfg.korow) + 4'(rf));

    always_comb
    begin
        if (cfg.op == bmr_pkg::OP_OPEN)
        begin
            mid_line = mid_raw & img_mask;
        end
        else
        begin
            mid_line = mid_kill ? '0 : (mid_raw & close_span);
        end
    end

    always_comb
    begin
        if (cascade)
        begin
            middle_window_next = {mid_eff[bmr_pkg::MAX_SE-2:0], mid_line};
            middle_fill_next   = bmr_pkg::fill_inc(mid_fill_eff);
            emit               = (mid_fill_eff >= 4'(cfg.kr - 3'd1));
        end
        else
        begin
            middle_window_next = mid_eff;
            middle_fill_next   = mid_fill_eff;
            emit               = (in_fill_eff >= 4'(lag));
        end
        input_fill_next = bmr_pkg::fill_inc(in_fill_eff);
    end

    always_comb
    begin
        if (draining)
        begin
            drain_next = (drain_reg == lag) ? 3'd0 : drain_reg + 3'd1;
        end
        else
        begin
            drain_next = (in_last_reg && (lag != 3'd0)) ? 3'd1 : 3'd0;
        end
    end

    assign in_full_next   = row_accept ? 1'b1 : (in_take ? 1'b0 : in_full_reg);
    assign b_valid_next   = tick_fire ? emit : (b_load ? 1'b0 : b_valid_reg);
    assign out_valid_next = b_load || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg       <= 1'b0;
            input_fill_reg    <= 4'd0;
            middle_fill_reg   <= 4'd0;
            clear_pending_reg <= 1'b1;
            drain_reg         <= 3'd0;
            b_valid_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            if (tick_fire)
            begin
                input_fill_reg    <= input_fill_next;
                middle_fill_reg   <= middle_fill_next;
                clear_pending_reg <= tick_final;
                drain_reg         <= drain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_accept)
        begin
            in_row_reg  <= row_item.row_bits;
            in_last_reg <= row_item.last_row;
        end
        if (tick_fire)
        begin
            input_window_reg  <= input_window_next;
            middle_window_reg <= middle_window_next;
            b_last_reg        <= tick_final;
        end
        if (b_load)
        begin
            out_item_reg.result_row <= res_raw[bmr_pkg::COL_OFS +: bmr_pkg::MAX_WIDTH];
            out_item_reg.last       <= b_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // final pass reads the windows as the last tick left them
    assign win_b = cascade ? middle_window_reg : inw_b;

    bmr_pkg::line_t res_pass;

    bmr_morph u_final_pass (
        .cfg        (cfg),
        .dilate     (dilate_b),
        .win        (win_b),
        .morph_line (res_pass)
    );

    assign res_raw      = res_pass & img_mask;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    // ---------------------------------------------------------------
    // checks
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        draining |-> (drain_reg <= lag))
        else $error("drain count beyond look-ahead");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_fire && tick_final) |=> (clear_pending_reg && !draining))
        else $error("image end did not schedule a window clear");

    a_pass_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && out_free) |=> result_valid)
        else $error("finished row did not reach the output register");

    a_hold_windows: assert property (@(posedge clk) disable iff (!rst_n)
        b_hold |=> ($stable(input_window_reg) && $stable(middle_window_reg)))
        else $error("windows moved under a pending final pass");

endmodule

`default_nettype wire
